// ===== rtl/dec_pkg.sv =====
// Shared constants and codes for the disc collision resolver.
// No dependencies; compiled first.
package dec_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int MASS_W          = 32;
  localparam int NORM_FRAC       = 26;
  localparam int WEIGHT_FRAC     = 24;

  typedef enum logic [1:0] {
    OUT_COINCIDENT = 2'd0,
    OUT_SEPARATING = 2'd1,
    OUT_IMPULSE    = 2'd2
  } outcome_t;

endpackage

// ===== rtl/dec_pair_if.sv =====
// Request channel carrying one pair of discs.
// Depends on dec_pkg.
interface dec_pair_if #(
  parameter int COORD_WIDTH = dec_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_pos_x;
  logic signed [COORD_WIDTH-1:0] a_pos_y;
  logic signed [COORD_WIDTH-1:0] a_vel_x;
  logic signed [COORD_WIDTH-1:0] a_vel_y;
  logic [COORD_WIDTH-2:0]        a_radius;
  logic [dec_pkg::MASS_W-1:0]    a_mass;
  logic signed [COORD_WIDTH-1:0] b_pos_x;
  logic signed [COORD_WIDTH-1:0] b_pos_y;
  logic signed [COORD_WIDTH-1:0] b_vel_x;
  logic signed [COORD_WIDTH-1:0] b_vel_y;
  logic [COORD_WIDTH-2:0]        b_radius;
  logic [dec_pkg::MASS_W-1:0]    b_mass;

  modport source (
    output valid, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
           b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass,
    input  ready
  );
  modport sink (
    input  valid, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
           b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass,
    output ready
  );
endinterface

// ===== rtl/dec_res_if.sv =====
// Result channel carrying one resolved pair of discs.
// Depends on dec_pkg.
interface dec_res_if #(
  parameter int COORD_WIDTH = dec_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_new_pos_x;
  logic signed [COORD_WIDTH-1:0] a_new_pos_y;
  logic signed [COORD_WIDTH-1:0] a_new_vel_x;
  logic signed [COORD_WIDTH-1:0] a_new_vel_y;
  logic signed [COORD_WIDTH-1:0] b_new_pos_x;
  logic signed [COORD_WIDTH-1:0] b_new_pos_y;
  logic signed [COORD_WIDTH-1:0] b_new_vel_x;
  logic signed [COORD_WIDTH-1:0] b_new_vel_y;
  dec_pkg::outcome_t             outcome;

  modport source (
    output valid, a_new_pos_x, a_new_pos_y, a_new_vel_x, a_new_vel_y,
           b_new_pos_x, b_new_pos_y, b_new_vel_x, b_new_vel_y, outcome,
    input  ready
  );
  modport sink (
    input  valid, a_new_pos_x, a_new_pos_y, a_new_vel_x, a_new_vel_y,
           b_new_pos_x, b_new_pos_y, b_new_vel_x, b_new_vel_y, outcome,
    output ready
  );
endinterface

// ===== rtl/dec_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
// Requires num <= den. Depends on dec_pkg only through the top level.
module dec_div_pipe #(
  parameter int DEN_W  = 33,
  parameter int Q_BITS = 25,
  parameter int TAG_W  = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DEN_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [TAG_W-1:0]  tag,
  output logic              out_vld,
  output logic [Q_BITS-1:0] quo,
  output logic [TAG_W-1:0]  out_tag
);

  logic [DEN_W:0]    rem [Q_BITS];
  logic [Q_BITS-1:0] qr  [Q_BITS];
  logic [DEN_W-1:0]  dv  [Q_BITS];
  logic [TAG_W-1:0]  tg  [Q_BITS];
  logic              vld [Q_BITS];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    logic [DEN_W:0]    r_in;
    logic [DEN_W-1:0]  d_in;
    logic [Q_BITS-1:0] q_in;
    logic [TAG_W-1:0]  t_in;
    logic              v_in;
    logic              take;

    if (i == 0) begin : g_first
      assign r_in = {1'b0, num};
      assign d_in = den;
      assign q_in = '0;
      assign t_in = tag;
      assign v_in = in_vld;
    end else begin : g_next
      assign r_in = {rem[i-1][DEN_W-1:0], 1'b0};
      assign d_in = dv[i-1];
      assign q_in = qr[i-1];
      assign t_in = tg[i-1];
      assign v_in = vld[i-1];
    end

    assign take = (r_in >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? (r_in - {1'b0, d_in}) : r_in;
        qr[i]  <= {q_in[Q_BITS-2:0], take};
        dv[i]  <= d_in;
        tg[i]  <= t_in;
      end
    end
  end

  assign out_vld = vld[Q_BITS-1];
  assign quo     = qr[Q_BITS-1];
  assign out_tag = tg[Q_BITS-1];

endmodule

// ===== rtl/dec_sqrt_pipe.sv =====
// Pipelined integer floor square root, one root bit per stage, with sideband tag.
// Depends on dec_pkg only through the top level.
module dec_sqrt_pipe #(
  parameter int IN_W  = 33,
  parameter int TAG_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [IN_W-1:0]         radicand,
  input  logic [TAG_W-1:0]        tag,
  output logic                    out_vld,
  output logic [(IN_W+1)/2-1:0]   root,
  output logic [TAG_W-1:0]        out_tag
);

  localparam int ROOT_W = (IN_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int RM_W   = ROOT_W + 3;

  logic [PAD_W-1:0]  rad [ROOT_W];
  logic [RM_W-1:0]   rem [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];
  logic [TAG_W-1:0]  tg  [ROOT_W];
  logic              vld [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [PAD_W-1:0]  rad_in;
    logic [RM_W-1:0]   rem_p;
    logic [ROOT_W-1:0] rt_p;
    logic [TAG_W-1:0]  t_in;
    logic              v_in;
    logic [RM_W-1:0]   cur;
    logic [RM_W-1:0]   trial;
    logic              take;

    if (i == 0) begin : g_first
      assign rad_in = PAD_W'(radicand);
      assign rem_p  = '0;
      assign rt_p   = '0;
      assign t_in   = tag;
      assign v_in   = in_vld;
    end else begin : g_next
      assign rad_in = rad[i-1];
      assign rem_p  = rem[i-1];
      assign rt_p   = rt[i-1];
      assign t_in   = tg[i-1];
      assign v_in   = vld[i-1];
    end

    assign cur   = {rem_p[RM_W-3:0], rad_in[PAD_W-1 -: 2]};
    assign trial = {1'b0, rt_p, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? (cur - trial) : cur;
        rt[i]  <= {rt_p[ROOT_W-2:0], take};
        rad[i] <= {rad_in[PAD_W-3:0], 2'b00};
        tg[i]  <= t_in;
      end
    end
  end

  assign out_vld = vld[ROOT_W-1];
  assign root    = rt[ROOT_W-1];
  assign out_tag = tg[ROOT_W-1];

endmodule

// ===== rtl/disc_elastic_collision_resolve_core.sv =====
// Top level of the elastic disc collision resolver: stage registers and datapath.
// Depends on dec_pkg, dec_pair_if, dec_res_if, dec_div_pipe, dec_sqrt_pipe.
//
//  channel | direction | handshake    | payload
//  --------+-----------+--------------+---------------------------------------------
//  pair    | in        | valid/ready  | two discs: position, velocity, radius, mass
//  res     | out       | valid/ready  | two discs: new position, new velocity, outcome
//
// One request enters per cycle while res is not stalled. The path runs through the weight
// divider, stage R1, the square root, the normal divider, stages P1 to P6 and the
// output register; the dividers and the square root retire one bit per stage.
// Reset (rst, synchronous) clears every valid bit; data registers hold garbage.
// A stall on res freezes the whole pipeline, including the output register.
module disc_elastic_collision_resolve_core #(
  parameter int COORD_WIDTH = dec_pkg::COORD_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  dec_pair_if.sink  pair,
  dec_res_if.source res
);
  import dec_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int RW     = W - 1;
  localparam int DW     = W + 1;
  localparam int SQ_W   = 2 * W + 1;
  localparam int QN     = NORM_FRAC + 1;
  localparam int NW     = NORM_FRAC + 2;
  localparam int QW     = WEIGHT_FRAC + 1;
  localparam int MSUM_W = MASS_W + 1;
  localparam int BASE_W = 8 * W + 2 * RW;
  localparam int PR_W   = DW + NW;
  localparam int DOT_W  = PR_W + 1;
  localparam int VN_W   = DOT_W - NORM_FRAC;
  localparam int PA_W   = VN_W + QW + 2;
  localparam int KA_W   = VN_W + 2;
  localparam int KN_W   = KA_W + NW;
  localparam int KV_W   = KN_W - NORM_FRAC;
  localparam int H_W    = W + 1;
  localparam int HN_W   = H_W + NW;
  localparam int HS_W   = HN_W - NORM_FRAC;
  localparam int OV_W   = W + 2;
  localparam int SAT_W  = KV_W + 2;
  localparam int SQT_W  = BASE_W + 2 * DW + 2 * QW;
  localparam int NXT_W  = BASE_W + 1 + DW + 2 * QW;

  // ---- helpers: divide by a power of two, rounding toward zero ----
  function automatic logic signed [VN_W-1:0] trunc_dot(input logic signed [DOT_W-1:0] x);
    logic signed [DOT_W-1:0] adj;
    adj = x + (x[DOT_W-1] ? {{(DOT_W-NORM_FRAC){1'b0}}, {NORM_FRAC{1'b1}}} : '0);
    return adj[DOT_W-1:NORM_FRAC];
  endfunction

  function automatic logic signed [KA_W-1:0] trunc_pa(input logic signed [PA_W-1:0] x);
    logic signed [PA_W-1:0] adj;
    adj = x + (x[PA_W-1] ? {{(PA_W-WEIGHT_FRAC){1'b0}}, {WEIGHT_FRAC{1'b1}}} : '0);
    return adj[WEIGHT_FRAC+KA_W-1:WEIGHT_FRAC];
  endfunction

  function automatic logic signed [KV_W-1:0] trunc_kn(input logic signed [KN_W-1:0] x);
    logic signed [KN_W-1:0] adj;
    adj = x + (x[KN_W-1] ? {{(KN_W-NORM_FRAC){1'b0}}, {NORM_FRAC{1'b1}}} : '0);
    return adj[KN_W-1:NORM_FRAC];
  endfunction

  function automatic logic signed [HS_W-1:0] trunc_hn(input logic signed [HN_W-1:0] x);
    logic signed [HN_W-1:0] adj;
    adj = x + (x[HN_W-1] ? {{(HN_W-NORM_FRAC){1'b0}}, {NORM_FRAC{1'b1}}} : '0);
    return adj[HN_W-1:NORM_FRAC];
  endfunction

  // Clamp to the signed coordinate range.
  function automatic logic signed [W-1:0] sat(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = {{(SAT_W-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = {{(SAT_W-W+1){1'b1}}, {(W-1){1'b0}}};
    if (v > hi) return hi[W-1:0];
    if (v < lo) return lo[W-1:0];
    return v[W-1:0];
  endfunction

  // ---- flow control: every stage advances when the output slot frees ----
  logic res_vld;
  logic adv;

  assign adv        = !res_vld || res.ready;
  assign pair.ready = adv;

  // ---- mass weights: wa = mb/(ma+mb), wb = ma/(ma+mb), Q.24 ----
  logic [MSUM_W-1:0] msum;
  logic [BASE_W-1:0] base_in;

  assign msum    = MSUM_W'(pair.a_mass) + MSUM_W'(pair.b_mass);
  assign base_in = {pair.a_pos_x, pair.a_pos_y, pair.a_vel_x, pair.a_vel_y,
                    pair.b_pos_x, pair.b_pos_y, pair.b_vel_x, pair.b_vel_y,
                    pair.a_radius, pair.b_radius};

  logic              wd_vld;
  logic [QW-1:0]     wa_q;
  logic [QW-1:0]     wb_q;
  logic [BASE_W-1:0] wd_base;
  logic              wd_mzero;

  dec_div_pipe #(.DEN_W(MSUM_W), .Q_BITS(QW), .TAG_W(BASE_W)) u_div_wa (
    .clk, .rst, .en(adv),
    .in_vld(pair.valid), .num(MSUM_W'(pair.b_mass)), .den(msum), .tag(base_in),
    .out_vld(wd_vld), .quo(wa_q), .out_tag(wd_base)
  );

  dec_div_pipe #(.DEN_W(MSUM_W), .Q_BITS(QW), .TAG_W(1)) u_div_wb (
    .clk, .rst, .en(adv),
    .in_vld(pair.valid), .num(MSUM_W'(pair.a_mass)), .den(msum), .tag(msum == '0),
    .out_vld(), .quo(wb_q), .out_tag(wd_mzero)
  );

  // ---- stage R1: center offset and its squares ----
  logic signed [W-1:0] w_apx, w_apy, w_bpx, w_bpy;
  logic signed [DW-1:0] w_dx, w_dy, w_adx, w_ady;

  assign w_apx = wd_base[BASE_W-1     -: W];
  assign w_apy = wd_base[BASE_W-1-W   -: W];
  assign w_bpx = wd_base[BASE_W-1-4*W -: W];
  assign w_bpy = wd_base[BASE_W-1-5*W -: W];
  assign w_dx  = DW'(w_bpx) - DW'(w_apx);
  assign w_dy  = DW'(w_bpy) - DW'(w_apy);
  assign w_adx = w_dx[DW-1] ? -w_dx : w_dx;
  assign w_ady = w_dy[DW-1] ? -w_dy : w_dy;

  logic              r1_vld;
  logic [BASE_W-1:0] r1_base;
  logic [DW-1:0]     r1_dx, r1_dy;
  logic [2*W-1:0]    r1_sqx, r1_sqy;
  logic [QW-1:0]     r1_wa, r1_wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_vld <= 1'b0;
    end else if (adv) begin
      r1_vld <= wd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_base <= wd_base;
      r1_dx   <= w_dx;
      r1_dy   <= w_dy;
      r1_sqx  <= w_adx[W-1:0] * w_adx[W-1:0];
      r1_sqy  <= w_ady[W-1:0] * w_ady[W-1:0];
      // both masses zero: split evenly
      r1_wa   <= wd_mzero ? QW'(1 << (WEIGHT_FRAC - 1)) : wa_q;
      r1_wb   <= wd_mzero ? QW'(1 << (WEIGHT_FRAC - 1)) : wb_q;
    end
  end

  // ---- center distance D = floor(sqrt(dx^2 + dy^2)) ----
  logic             sq_vld;
  logic [DW-1:0]    sq_d;
  logic [SQT_W-1:0] sq_tag;

  dec_sqrt_pipe #(.IN_W(SQ_W), .TAG_W(SQT_W)) u_sqrt (
    .clk, .rst, .en(adv),
    .in_vld(r1_vld), .radicand(SQ_W'(r1_sqx) + SQ_W'(r1_sqy)),
    .tag({r1_base, r1_dx, r1_dy, r1_wa, r1_wb}),
    .out_vld(sq_vld), .root(sq_d), .out_tag(sq_tag)
  );

  logic [BASE_W-1:0]    sq_base;
  logic signed [DW-1:0] sq_dx, sq_dy, sq_adx, sq_ady;
  logic [QW-1:0]        sq_wa, sq_wb;

  assign {sq_base, sq_dx, sq_dy, sq_wa, sq_wb} = sq_tag;
  assign sq_adx = sq_dx[DW-1] ? -sq_dx : sq_dx;
  assign sq_ady = sq_dy[DW-1] ? -sq_dy : sq_dy;

  // ---- unit normal magnitudes |d|*2^26/D; |d| <= D keeps them within 2^26 ----
  logic             nd_vld;
  logic [QN-1:0]    qx, qy;
  logic [NXT_W-1:0] nd_tag;
  logic             nd_sy;

  dec_div_pipe #(.DEN_W(DW), .Q_BITS(QN), .TAG_W(NXT_W)) u_div_nx (
    .clk, .rst, .en(adv),
    .in_vld(sq_vld), .num(sq_adx), .den(sq_d),
    .tag({sq_base, sq_dx[DW-1], sq_d, sq_wa, sq_wb}),
    .out_vld(nd_vld), .quo(qx), .out_tag(nd_tag)
  );

  dec_div_pipe #(.DEN_W(DW), .Q_BITS(QN), .TAG_W(1)) u_div_ny (
    .clk, .rst, .en(adv),
    .in_vld(sq_vld), .num(sq_ady), .den(sq_d), .tag(sq_dy[DW-1]),
    .out_vld(), .quo(qy), .out_tag(nd_sy)
  );

  logic [BASE_W-1:0] nd_base;
  logic              nd_sx;
  logic [DW-1:0]     nd_d;
  logic [QW-1:0]     nd_wa, nd_wb;
  logic signed [W-1:0] n_avx, n_avy, n_bvx, n_bvy;
  logic [RW-1:0]     n_ra, n_rb;

  assign {nd_base, nd_sx, nd_d, nd_wa, nd_wb} = nd_tag;
  assign n_avx = nd_base[BASE_W-1-2*W -: W];
  assign n_avy = nd_base[BASE_W-1-3*W -: W];
  assign n_bvx = nd_base[BASE_W-1-6*W -: W];
  assign n_bvy = nd_base[BASE_W-1-7*W -: W];
  assign n_ra  = nd_base[2*RW-1 -: RW];
  assign n_rb  = nd_base[RW-1:0];

  // ---- stage P1: signed normal, relative velocity, overlap ----
  logic                  p1_vld;
  logic [BASE_W-1:0]     p1_base;
  logic signed [NW-1:0]  p1_nx, p1_ny;
  logic signed [DW-1:0]  p1_rvx, p1_rvy;
  logic signed [OV_W-1:0] p1_ov;
  logic [DW-1:0]         p1_d;
  logic [QW-1:0]         p1_wa, p1_wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (adv) begin
      p1_vld <= nd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_base <= nd_base;
      p1_nx   <= nd_sx ? -NW'(qx) : NW'(qx);
      p1_ny   <= nd_sy ? -NW'(qy) : NW'(qy);
      p1_rvx  <= DW'(n_bvx) - DW'(n_avx);
      p1_rvy  <= DW'(n_bvy) - DW'(n_avy);
      p1_ov   <= OV_W'(n_ra) + OV_W'(n_rb) - OV_W'(nd_d);
      p1_d    <= nd_d;
      p1_wa   <= nd_wa;
      p1_wb   <= nd_wb;
    end
  end

  // ---- stage P2: normal velocity products ----
  logic                   p2_vld;
  logic [BASE_W-1:0]      p2_base;
  logic signed [PR_W-1:0] p2_px, p2_py;
  logic signed [NW-1:0]   p2_nx, p2_ny;
  logic signed [OV_W-1:0] p2_ov;
  logic [DW-1:0]          p2_d;
  logic [QW-1:0]          p2_wa, p2_wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (adv) begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_base <= p1_base;
      p2_px   <= p1_rvx * p1_nx;
      p2_py   <= p1_rvy * p1_ny;
      p2_nx   <= p1_nx;
      p2_ny   <= p1_ny;
      p2_ov   <= p1_ov;
      p2_d    <= p1_d;
      p2_wa   <= p1_wa;
      p2_wb   <= p1_wb;
    end
  end

  // ---- stage P3: dot product, classification, half overlap ----
  logic signed [DOT_W-1:0] dot;
  outcome_t                p3_outc_next;

  assign dot = DOT_W'(p2_px) + DOT_W'(p2_py);

  always_comb begin
    if (p2_d == '0) begin
      p3_outc_next = OUT_COINCIDENT;
    end else if (!dot[DOT_W-1] && dot != '0) begin
      p3_outc_next = OUT_SEPARATING;
    end else begin
      p3_outc_next = OUT_IMPULSE;
    end
  end

  logic                   p3_vld;
  logic [BASE_W-1:0]      p3_base;
  logic signed [VN_W-1:0] p3_vn;
  outcome_t               p3_outc;
  logic signed [H_W-1:0]  p3_h;
  logic signed [NW-1:0]   p3_nx, p3_ny;
  logic [QW-1:0]          p3_wa, p3_wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else if (adv) begin
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_base <= p2_base;
      p3_vn   <= trunc_dot(dot);
      p3_outc <= p3_outc_next;
      // no overlap: no separation
      p3_h    <= (!p2_ov[OV_W-1] && p2_ov != '0) ? {1'b0, p2_ov[W:1]} : '0;
      p3_nx   <= p2_nx;
      p3_ny   <= p2_ny;
      p3_wa   <= p2_wa;
      p3_wb   <= p2_wb;
    end
  end

  // ---- stage P4: impulse scaled by mass weights ----
  logic signed [VN_W:0] vn2;
  logic signed [QW:0]   wa_s, wb_s;

  assign vn2  = {p3_vn, 1'b0};
  assign wa_s = {1'b0, p3_wa};
  assign wb_s = {1'b0, p3_wb};

  logic                   p4_vld;
  logic [BASE_W-1:0]      p4_base;
  logic signed [PA_W-1:0] p4_pa, p4_pb;
  outcome_t               p4_outc;
  logic signed [H_W-1:0]  p4_h;
  logic signed [NW-1:0]   p4_nx, p4_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld <= 1'b0;
    end else if (adv) begin
      p4_vld <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_base <= p3_base;
      p4_pa   <= vn2 * wa_s;
      p4_pb   <= vn2 * wb_s;
      p4_outc <= p3_outc;
      p4_h    <= p3_h;
      p4_nx   <= p3_nx;
      p4_ny   <= p3_ny;
    end
  end

  // ---- stage P5: back to Q.0 velocity units, dropping the Q.24 weight fraction ----
  logic                   p5_vld;
  logic [BASE_W-1:0]      p5_base;
  logic signed [KA_W-1:0] p5_ka, p5_kb;
  outcome_t               p5_outc;
  logic signed [H_W-1:0]  p5_h;
  logic signed [NW-1:0]   p5_nx, p5_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_vld <= 1'b0;
    end else if (adv) begin
      p5_vld <= p4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_base <= p4_base;
      p5_ka   <= trunc_pa(p4_pa);
      p5_kb   <= trunc_pa(p4_pb);
      p5_outc <= p4_outc;
      p5_h    <= p4_h;
      p5_nx   <= p4_nx;
      p5_ny   <= p4_ny;
    end
  end

  // ---- stage P6: project impulse and separation onto the normal ----
  logic                   p6_vld;
  logic [BASE_W-1:0]      p6_base;
  logic signed [KN_W-1:0] p6_kax, p6_kay, p6_kbx, p6_kby;
  logic signed [HN_W-1:0] p6_hx, p6_hy;
  outcome_t               p6_outc;

  always_ff @(posedge clk) begin
    if (rst) begin
      p6_vld <= 1'b0;
    end else if (adv) begin
      p6_vld <= p5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_base <= p5_base;
      p6_kax  <= p5_ka * p5_nx;
      p6_kay  <= p5_ka * p5_ny;
      p6_kbx  <= p5_kb * p5_nx;
      p6_kby  <= p5_kb * p5_ny;
      p6_hx   <= p5_h * p5_nx;
      p6_hy   <= p5_h * p5_ny;
      p6_outc <= p5_outc;
    end
  end

  // ---- stage P7: apply, saturate, or pass the inputs through ----
  logic signed [W-1:0]  f_apx, f_apy, f_avx, f_avy, f_bpx, f_bpy, f_bvx, f_bvy;
  logic signed [HS_W-1:0] sx, sy;

  assign {f_apx, f_apy, f_avx, f_avy, f_bpx, f_bpy, f_bvx, f_bvy} = p6_base[BASE_W-1:2*RW];
  assign sx = trunc_hn(p6_hx);
  assign sy = trunc_hn(p6_hy);

  logic signed [W-1:0] o_apx, o_apy, o_avx, o_avy, o_bpx, o_bpy, o_bvx, o_bvy;

  always_comb begin
    o_apx = f_apx;
    o_apy = f_apy;
    o_avx = f_avx;
    o_avy = f_avy;
    o_bpx = f_bpx;
    o_bpy = f_bpy;
    o_bvx = f_bvx;
    o_bvy = f_bvy;
    if (p6_outc == OUT_IMPULSE) begin
      o_avx = sat(SAT_W'(f_avx) + SAT_W'(trunc_kn(p6_kax)));
      o_avy = sat(SAT_W'(f_avy) + SAT_W'(trunc_kn(p6_kay)));
      o_bvx = sat(SAT_W'(f_bvx) - SAT_W'(trunc_kn(p6_kbx)));
      o_bvy = sat(SAT_W'(f_bvy) - SAT_W'(trunc_kn(p6_kby)));
      o_apx = sat(SAT_W'(f_apx) - SAT_W'(sx));
      o_apy = sat(SAT_W'(f_apy) - SAT_W'(sy));
      o_bpx = sat(SAT_W'(f_bpx) + SAT_W'(sx));
      o_bpy = sat(SAT_W'(f_bpy) + SAT_W'(sy));
    end
  end

  // Output register: holds the result while res stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= p6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.a_new_pos_x <= o_apx;
      res.a_new_pos_y <= o_apy;
      res.a_new_vel_x <= o_avx;
      res.a_new_vel_y <= o_avy;
      res.b_new_pos_x <= o_bpx;
      res.b_new_pos_y <= o_bpy;
      res.b_new_vel_x <= o_bvx;
      res.b_new_vel_y <= o_bvy;
      res.outcome     <= p6_outc;
    end
  end

  assign res.valid = res_vld;

endmodule
